>>> rtl/vrs_pkg.sv
// vrs_pkg: shared widths, codes and reset values of the vector reservoir sampler
// no dependencies; used by the channel interfaces and the top level
package vrs_pkg;

    localparam int ELEM_W     = 32;
    localparam int RSLOT_W    = 8;
    localparam int RIDX_W     = 7;
    localparam int FILL_OUT_W = 9;
    localparam int SEEN_W     = 40;
    localparam int SCNT_W     = 9;
    localparam int DIM_W      = 8;
    localparam int CMP_W      = 17;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    typedef logic [ELEM_W-1:0] t_elem;

    localparam logic              MODE_OFFER       = 1'b0;
    localparam logic              MODE_READ        = 1'b1;
    localparam logic              REG_SAMPLE_COUNT = 1'b0;
    localparam logic              REG_DIMENSION    = 1'b1;
    localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RST = 9'd256;
    localparam logic [DIM_W-1:0]  DIMENSION_RST    = 8'd128;

endpackage

>>> rtl/vrs_item_if.sv
// vrs_item_if: input item channel of the reservoir sampler
// depends on vrs_pkg
interface vrs_item_if import vrs_pkg::*;;
    logic               valid;
    logic               ready;
    logic               mode;
    t_elem              element_value;
    logic               last_element;
    logic [ELEM_W-1:0]  random_word;
    logic [RSLOT_W-1:0] read_slot;
    logic [RIDX_W-1:0]  read_index;

    modport source (
        output valid, mode, element_value, last_element, random_word, read_slot, read_index,
        input  ready
    );
    modport sink (
        input  valid, mode, element_value, last_element, random_word, read_slot, read_index,
        output ready
    );
endinterface

>>> rtl/vrs_result_if.sv
// vrs_result_if: result channel of the reservoir sampler
// depends on vrs_pkg
interface vrs_result_if import vrs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  kept;
    logic [RSLOT_W-1:0]    target_slot;
    logic [FILL_OUT_W-1:0] filled_slots;
    logic [SEEN_W-1:0]     vectors_seen;
    t_elem                 read_value;
    logic                  at_end;

    modport source (
        output valid, kept, target_slot, filled_slots, vectors_seen, read_value, at_end,
        input  ready
    );
    modport sink (
        input  valid, kept, target_slot, filled_slots, vectors_seen, read_value, at_end,
        output ready
    );
endinterface

>>> rtl/vector_reservoir_sampler_unit.sv
// vector_reservoir_sampler_unit: reservoir sampler (algorithm R) over streamed vectors
// depends on vrs_pkg, vrs_item_if and vrs_result_if
//
// Keeps a uniform random sample of up to sample_count vectors in one sample memory
// of SLOT_CAPACITY x MAX_DIMENSION 32-bit words with a registered read. Items are
// handled one at a time by a small sequencer: a stream element goes through decide,
// memory write and result; the first element of a vector that arrives once the
// reservoir is full adds a draw, a registered multiply of the random word by the
// 41-bit seen count plus one, then an add and compare; a read item goes through
// decide with memory read, then result. A new item is taken while the previous
// result still waits in the output register. There is no clearing pass after
// reset; reading a slot position that no vector ever wrote returns undefined data.
module vector_reservoir_sampler_unit import vrs_pkg::*; #(
    parameter int SLOT_CAPACITY = 256,
    parameter int MAX_DIMENSION = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    vrs_item_if.sink           i_item,
    vrs_result_if.source       o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int SLOT_AW = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int FILL_W  = $clog2(SLOT_CAPACITY + 1);
    localparam int POS_W   = $clog2(MAX_DIMENSION + 1);
    localparam int DEPTH   = SLOT_CAPACITY * MAX_DIMENSION;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DRAW   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [SCNT_W-1:0]   r_sample_count;
    logic [DIM_W-1:0]    r_dimension;
    logic [SEEN_W-1:0]   r_seen, n_seen;
    logic [FILL_W-1:0]   r_filled, n_filled;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_keep, n_keep;
    logic [SLOT_AW-1:0]  r_slot, n_slot;

    logic                r_mode;
    t_elem               r_elem;
    logic                r_last;
    logic [ELEM_W-1:0]   r_rnd;
    logic [RSLOT_W-1:0]  r_rslot;
    logic [RIDX_W-1:0]   r_ridx;

    logic [SEEN_W:0]     r_p_hi;
    logic [63:0]         r_p_lo;
    logic                r_rd_end, r_rd_ok;
    t_elem               r_rd_data;

    logic                  r_out_valid;
    logic                  r_out_kept;
    logic [RSLOT_W-1:0]    r_out_tslot;
    logic [FILL_OUT_W-1:0] r_out_filled;
    logic [SEEN_W-1:0]     r_out_seen;
    t_elem                 r_out_rval;
    logic                  r_out_end;

    t_elem               r_mem [DEPTH];

    logic                accept;
    logic                out_free;
    logic                cfg_wr;
    logic [CMP_W-1:0]    eff_slots;
    logic [CMP_W-1:0]    eff_dim;
    logic [SEEN_W:0]     draw_n;
    logic [SEEN_W:0]     draw_j;
    logic                wr_en;
    logic [31:0]         wr_addr_w;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_end, rd_ok;
    logic [31:0]         rd_addr_w;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_en;

    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_DIMENSION) ? PDATA_W'(r_dimension)
                                                  : PDATA_W'(r_sample_count);

    assign i_item.ready = (r_state == S_IDLE);

    assign eff_slots = (CMP_W'(r_sample_count) > CMP_W'(SLOT_CAPACITY))
                     ? CMP_W'(SLOT_CAPACITY) : CMP_W'(r_sample_count);
    assign eff_dim   = (CMP_W'(r_dimension) > CMP_W'(MAX_DIMENSION))
                     ? CMP_W'(MAX_DIMENSION) : CMP_W'(r_dimension);

    assign draw_n = (SEEN_W+1)'(r_seen) + (SEEN_W+1)'(1);
    assign draw_j = r_p_hi + (SEEN_W+1)'(r_p_lo[63:32]);

    assign wr_en     = (r_state == S_WRITE) && r_keep && (CMP_W'(r_pos) < eff_dim);
    assign wr_addr_w = 32'(r_slot) * 32'(MAX_DIMENSION) + 32'(r_pos);
    assign wr_addr   = wr_addr_w[ADDR_W-1:0];

    assign rd_end    = (CMP_W'(r_rslot) >= CMP_W'(r_filled))
                    || (CMP_W'(r_rslot) >= CMP_W'(SLOT_CAPACITY));
    assign rd_ok     = !rd_end && (CMP_W'(r_ridx) < eff_dim);
    assign rd_en     = (r_state == S_DECIDE) && (r_mode == MODE_READ) && rd_ok;
    assign rd_addr_w = 32'(r_rslot) * 32'(MAX_DIMENSION) + 32'(r_ridx);
    assign rd_addr   = rd_addr_w[ADDR_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_seen   = r_seen;
        n_filled = r_filled;
        n_pos    = r_pos;
        n_keep   = r_keep;
        n_slot   = r_slot;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_mode == MODE_READ) begin
                    n_state = S_DONE;
                end else if (r_pos == '0) begin
                    if (r_seen != '1) begin
                        n_seen = r_seen + SEEN_W'(1);
                    end
                    if (CMP_W'(r_filled) < eff_slots) begin
                        n_keep   = 1'b1;
                        n_slot   = SLOT_AW'(r_filled);
                        n_filled = r_filled + FILL_W'(1);
                        n_state  = S_WRITE;
                    end else begin
                        n_state = S_DRAW;
                    end
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DRAW: begin
                if (draw_j < (SEEN_W+1)'(eff_slots)) begin
                    n_keep = 1'b1;
                    n_slot = SLOT_AW'(draw_j);
                end else begin
                    n_keep = 1'b0;
                    n_slot = '0;
                end
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (r_last) begin
                    n_pos = '0;
                end else if (CMP_W'(r_pos) < CMP_W'(MAX_DIMENSION)) begin
                    n_pos = r_pos + POS_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sample_count <= SAMPLE_COUNT_RST;
            r_dimension    <= DIMENSION_RST;
            r_seen         <= '0;
            r_filled       <= '0;
            r_pos          <= '0;
            r_keep         <= 1'b0;
            r_slot         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_filled <= n_filled;
            r_pos    <= n_pos;
            r_keep   <= n_keep;
            r_slot   <= n_slot;
            if (cfg_wr) begin
                if (paddr[2] == REG_SAMPLE_COUNT) begin
                    r_sample_count <= pwdata[SCNT_W-1:0];
                end else begin
                    r_dimension <= pwdata[DIM_W-1:0];
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_item.mode;
            r_elem  <= i_item.element_value;
            r_last  <= i_item.last_element;
            r_rnd   <= i_item.random_word;
            r_rslot <= i_item.read_slot;
            r_ridx  <= i_item.read_index;
        end
        if (r_state == S_DECIDE) begin
            r_p_hi   <= (SEEN_W+1)'(r_rnd) * (SEEN_W+1)'(draw_n[SEEN_W:32]);
            r_p_lo   <= 64'(r_rnd) * 64'(draw_n[31:0]);
            r_rd_end <= rd_end;
            r_rd_ok  <= rd_ok;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_filled <= FILL_OUT_W'(r_filled);
            r_out_seen   <= r_seen;
            if (r_mode == MODE_READ) begin
                r_out_kept  <= 1'b0;
                r_out_tslot <= '0;
                r_out_rval  <= r_rd_ok ? r_rd_data : '0;
                r_out_end   <= r_rd_end;
            end else begin
                r_out_kept  <= r_keep;
                r_out_tslot <= r_keep ? RSLOT_W'(r_slot) : '0;
                r_out_rval  <= '0;
                r_out_end   <= 1'b0;
            end
        end
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_elem;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.kept         = r_out_kept;
    assign o_result.target_slot  = r_out_tslot;
    assign o_result.filled_slots = r_out_filled;
    assign o_result.vectors_seen = r_out_seen;
    assign o_result.read_value   = r_out_rval;
    assign o_result.at_end       = r_out_end;

    a_seen_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_seen >= $past(r_seen)))
        else $error("seen counter went backward");

    a_filled_on_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_filled != $past(r_filled))) |-> $past(r_state == S_DECIDE))
        else $error("fill count changed outside a decision");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_result.ready) |=> (r_state == S_DONE))
        else $error("result dropped while output register busy");

    a_end_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> (r_out_rval == '0 && !r_out_kept))
        else $error("end-of-store read carries data");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench of vector_reservoir_sampler_unit, directed then random beats
// depends on vrs_pkg, vrs_item_if, vrs_result_if and the top level of the sampler
module testbench import vrs_pkg::*;;

    localparam int SLOTS = 256;
    localparam int DIMS = 128;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    typedef struct packed {
        logic               mode;
        t_elem              element_value;
        logic               last_element;
        logic [ELEM_W-1:0]  random_word;
        logic [RSLOT_W-1:0] read_slot;
        logic [RIDX_W-1:0]  read_index;
    } t_item;

    typedef struct packed {
        logic                  kept;
        logic [RSLOT_W-1:0]    target_slot;
        logic [FILL_OUT_W-1:0] filled_slots;
        logic [SEEN_W-1:0]     vectors_seen;
        t_elem                 read_value;
        logic                  at_end;
    } t_result;

    class sample_tracker;
        logic [SCNT_W-1:0]     slot_limit;
        logic [DIM_W-1:0]      vec_dim;
        logic [SEEN_W-1:0]     seen;
        logic [FILL_OUT_W-1:0] filled;
        logic [7:0]            position;
        bit                    keep;
        logic [RSLOT_W-1:0]    slot;
        t_elem                 store [SLOTS*DIMS];
        bit                    written [SLOTS*DIMS];
        t_result               pending_results [$];
        int                    errors;

        function new();
            slot_limit = SAMPLE_COUNT_RST;
            vec_dim = DIMENSION_RST;
            seen = '0;
            filled = '0;
            position = '0;
            keep = 1'b0;
            slot = '0;
            errors = 0;
        endfunction

        function int unsigned used_slots();
            return (slot_limit > SLOTS) ? SLOTS : slot_limit;
        endfunction

        function int unsigned used_dim();
            return (vec_dim > DIMS) ? DIMS : vec_dim;
        endfunction

        function void write_config(logic reg_idx, logic [PDATA_W-1:0] value);
            if (reg_idx == REG_SAMPLE_COUNT) begin
                slot_limit = value[SCNT_W-1:0];
            end else begin
                vec_dim = value[DIM_W-1:0];
            end
        endfunction

        function bit read_defined(logic [7:0] s, logic [6:0] i);
            return !(s < filled && i < used_dim() && !written[int'(s)*DIMS + int'(i)]);
        endfunction

        function bit find_written(output logic [7:0] s, output logic [6:0] i);
            int k;
            s = '0;
            i = '0;
            for (k = 0; k < SLOTS*DIMS; k++) begin
                if (written[k]) begin
                    s = 8'(k / DIMS);
                    i = 7'(k % DIMS);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void take_item(t_item it);
            t_result r;
            logic [71:0] product;
            logic [SEEN_W-1:0] draw;
            r = '0;
            if (it.mode == MODE_OFFER) begin
                if (position == 0) begin
                    if (filled < used_slots()) begin
                        keep = 1'b1;
                        slot = filled[7:0];
                        filled++;
                    end else begin
                        product = 72'(it.random_word) * 72'({1'b0, seen} + 41'd1);
                        draw = product[71:32];
                        keep = (draw < used_slots());
                        slot = keep ? draw[7:0] : '0;
                    end
                    if (seen != SEEN_MAX) seen++;
                end
                if (keep && position < used_dim()) begin
                    store[int'(slot)*DIMS + int'(position)] = it.element_value;
                    written[int'(slot)*DIMS + int'(position)] = 1'b1;
                end
                r.kept = keep;
                r.target_slot = keep ? slot : '0;
                if (it.last_element) begin
                    position = '0;
                end else if (position < DIMS) begin
                    position++;
                end
            end else begin
                if (it.read_slot >= filled) begin
                    r.at_end = 1'b1;
                end else if (it.read_index < used_dim()) begin
                    r.read_value = store[int'(it.read_slot)*DIMS + int'(it.read_index)];
                end
            end
            r.filled_slots = filled;
            r.vectors_seen = seen;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %0h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kept", want.kept, got.kept);
            compare_field("target_slot", want.target_slot, got.target_slot);
            compare_field("filled_slots", want.filled_slots, got.filled_slots);
            compare_field("vectors_seen", want.vectors_seen, got.vectors_seen);
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("at_end", want.at_end, got.at_end);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    vrs_item_if   item_ch ();
    vrs_result_if result_ch ();

    sample_tracker tracker = new();

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int hold_left;
    int cycle_count;

    int unsigned cfg_count [8] = '{4, 256, 1, 511, 0, 16, 37, 256};
    int unsigned cfg_dim [8] = '{8, 128, 1, 255, 5, 0, 16, 3};

    vector_reservoir_sampler_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("vector_reservoir_sampler_unit: mismatch");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = 120;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ch.ready = 1'b0;
        end else begin
            result_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = {result_ch.kept, result_ch.target_slot, result_ch.filled_slots,
                   result_ch.vectors_seen, result_ch.read_value, result_ch.at_end};
            tracker.match_result(got);
        end
    end

    function automatic t_item random_fields();
        t_item it;
        it.mode = 1'($urandom);
        it.element_value = $urandom;
        it.last_element = 1'($urandom);
        it.random_word = $urandom;
        it.read_slot = 8'($urandom);
        it.read_index = 7'($urandom);
        return it;
    endfunction

    function automatic t_item make_offer(t_elem v, logic last, logic [ELEM_W-1:0] rw);
        t_item it;
        it = random_fields();
        it.mode = MODE_OFFER;
        it.element_value = v;
        it.last_element = last;
        it.random_word = rw;
        return it;
    endfunction

    function automatic t_item make_read(logic [7:0] s, logic [6:0] i);
        t_item it;
        it = random_fields();
        it.mode = MODE_READ;
        it.read_slot = s;
        it.read_index = i;
        return it;
    endfunction

    // picks a read that never lands on a store word nobody wrote
    function automatic bit pick_read(output t_item it);
        logic [7:0] s;
        logic [6:0] i;
        int tries;
        s = '0;
        i = '0;
        for (tries = 0; tries < 8; tries++) begin
            s = (tracker.filled != 0 && $urandom_range(0, 99) < 70)
                ? 8'($urandom_range(0, int'(tracker.filled) - 1)) : 8'($urandom);
            i = ($urandom_range(0, 99) < 70) ? 7'($urandom_range(0, 7)) : 7'($urandom);
            if (tracker.read_defined(s, i)) begin
                it = make_read(s, i);
                return 1'b1;
            end
        end
        if (tracker.filled < SLOTS) begin
            it = make_read(8'($urandom_range(int'(tracker.filled), SLOTS-1)), i);
            return 1'b1;
        end
        if (tracker.used_dim() < DIMS) begin
            it = make_read(s, 7'($urandom_range(tracker.used_dim(), DIMS-1)));
            return 1'b1;
        end
        if (tracker.find_written(s, i)) begin
            it = make_read(s, i);
            return 1'b1;
        end
        it = make_read(s, i);
        return 1'b0;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_item(t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        item_ch.mode = it.mode;
        item_ch.element_value = it.element_value;
        item_ch.last_element = it.last_element;
        item_ch.random_word = it.random_word;
        item_ch.read_slot = it.read_slot;
        item_ch.read_index = it.read_index;
        item_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        tracker.take_item(it);
        @(negedge i_clk);
        item_ch.valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic reg_idx, logic [PDATA_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.write_config(reg_idx, value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial begin : stimulus
        t_item it;
        int phase;
        int sent;
        int remaining;
        int span;
        logic [ELEM_W-1:0] rw;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.mode = MODE_OFFER;
        item_ch.element_value = '0;
        item_ch.last_element = 1'b0;
        item_ch.random_word = '0;
        item_ch.read_slot = '0;
        item_ch.read_index = '0;
        result_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        cycle_count = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: fill, surplus drop, short vector, draw miss and hit, odd registers
        write_reg(REG_SAMPLE_COUNT, 32'd2);
        write_reg(REG_DIMENSION, 32'd3);
        send_item(make_read(8'd0, 7'd0));
        send_item(make_read(8'd255, 7'd127));
        send_item(make_offer(32'h0000_0000, 1'b0, 32'h0000_0000));
        send_item(make_read(8'd0, 7'd0));
        send_item(make_offer(32'hFFFF_FFFF, 1'b0, $urandom));
        send_item(make_offer(32'hA5A5_A5A5, 1'b0, $urandom));
        send_item(make_offer(32'h5A5A_5A5A, 1'b1, $urandom));
        send_item(make_offer(32'h1234_5678, 1'b0, 32'hFFFF_FFFF));
        send_item(make_offer(32'h8765_4321, 1'b1, $urandom));
        send_item(make_read(8'd0, 7'd2));
        send_item(make_read(8'd0, 7'd3));
        send_item(make_read(8'd1, 7'd1));
        send_item(make_read(8'd2, 7'd0));
        send_item(make_offer(32'h0F0F_0F0F, 1'b1, 32'hFFFF_FFFF));
        send_item(make_offer(32'hDEAD_BEEF, 1'b1, 32'h0000_0000));
        send_item(make_read(8'd0, 7'd1));
        send_item(make_read(8'd0, 7'd0));
        wait_drain();
        write_reg(REG_SAMPLE_COUNT, 32'd0);
        write_reg(REG_DIMENSION, 32'd0);
        send_item(make_offer(32'h1111_2222, 1'b1, 32'h0000_0000));
        send_item(make_read(8'd1, 7'd0));
        send_item(make_read(8'd2, 7'd0));
        wait_drain();
        write_reg(REG_SAMPLE_COUNT, 32'd511);
        write_reg(REG_DIMENSION, 32'd255);
        send_item(make_offer(32'hCAFE_F00D, 1'b0, $urandom));
        send_item(make_offer(32'h7FFF_FFFF, 1'b1, $urandom));
        send_item(make_read(8'd2, 7'd1));
        send_item(make_read(8'd0, 7'd2));
        send_item(make_read(8'd3, 7'd0));

        for (phase = 0; phase < 8; phase++) begin
            wait_drain();
            write_reg(REG_SAMPLE_COUNT, cfg_count[phase]);
            write_reg(REG_DIMENSION, cfg_dim[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            sent = 0;
            remaining = 0;
            while (sent < ITEMS_PER_PHASE || remaining != 0) begin
                if (remaining == 0) begin
                    span = (tracker.used_dim() < 4) ? tracker.used_dim() : 4;
                    remaining = ($urandom_range(0, 9) == 0)
                        ? $urandom_range(1, tracker.used_dim() + 3)
                        : $urandom_range(1, span + 2);
                end
                if ($urandom_range(0, 99) < 25 && pick_read(it)) begin
                    send_item(it);
                end else begin
                    case ($urandom_range(0, 9))
                        0: rw = '0;
                        1: rw = '1;
                        2, 3, 4: rw = $urandom_range(0, 32'h007F_FFFF);
                        default: rw = $urandom;
                    endcase
                    send_item(make_offer($urandom, remaining == 1, rw));
                    remaining--;
                end
                sent++;
                if (phase == 0 && sent == 40) hold_request = 1'b1;
                if (phase == 1 && sent == 90) wait_drain();
            end
        end

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("vector_reservoir_sampler_unit: match");
        end else begin
            $display("vector_reservoir_sampler_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/vrs_pkg.sv
rtl/vrs_item_if.sv
rtl/vrs_result_if.sv
rtl/vector_reservoir_sampler_unit.sv
tb/testbench.sv
